// ===== rtl/bfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsf_pkg
// Types, codes and a helper function shared by the bitmap free-slot finder.
// ----------------------------------------------------------------------------
package bfsf_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int REQ_W     = 7;
  localparam int LIMIT_W   = 11;
  localparam int INDEX_W   = 10;
  localparam int WSEL_W    = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_LD   = 2'd2,
    S_SCAN = 2'd3
  } state_e;

  typedef struct packed {
    logic    wr_en;
    logic    start;
    logic    rd_word;
    logic    load_word;
    logic    next_word;
    logic    emit;
    status_e emit_status;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic word_empty;
    logic word_last;
    logic over_lim;
    logic count_hit;
    logic out_free;
  } sts_t;

  // Bit position of a one-hot word; each output bit ORs independent inputs.
  function automatic logic [BIT_W-1:0] onehot_to_bin(input logic [WORD_BITS-1:0] oh);
    logic [BIT_W-1:0] res;
    res = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        res = res | BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/bfsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsf_ctrl
// Sequencer for the free-slot scan: accepts beats, steps the word reads and
// decides when a result beat is produced and when a run ends.
// ----------------------------------------------------------------------------
module bfsf_ctrl
  import bfsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic action_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == ACT_REQUEST) begin
            cmd_o.start = 1'b1;
            state_d     = S_RD;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_word = 1'b1;
        state_d       = S_LD;
      end
      S_LD: begin
        cmd_o.load_word = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.word_empty) begin
          if (!sts_i.word_last) begin
            cmd_o.next_word = 1'b1;
            state_d         = S_RD;
          end else if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_NONE;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.over_lim ? ST_OVER : ST_OK;
          cmd_o.emit_last   = sts_i.over_lim | sts_i.count_hit;
          if (sts_i.over_lim || sts_i.count_hit) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A result beat is only produced when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result produced while output register was occupied");

  // Moving to the next word always restarts the read sequence.
  a_next_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmd_o.next_word) |=> (state_q == S_RD))
    else $error("next word did not start a read");
`endif

endmodule

// ===== rtl/bfsf_dp.sv =====
// ----------------------------------------------------------------------------
// bfsf_dp
// Datapath of the free-slot finder: occupancy memory, word pointer, free
// mask with priority pick, limit compare, count and output register.
// ----------------------------------------------------------------------------
module bfsf_dp
  import bfsf_pkg::*;
#(
  parameter int BITMAP_WORDS = 32,
  parameter int MAX_REQUEST  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [LIMIT_W-1:0]   cfg_wr_data_i,
  input  logic [WSEL_W-1:0]    word_select_i,
  input  logic [WORD_BITS-1:0] word_value_i,
  input  logic [REQ_W-1:0]     requested_i,
  input  logic                 out_stall_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output logic [INDEX_W-1:0]   slot_index_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  localparam int WPTR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int IDX_W  = WPTR_W + BIT_W;
  localparam int CMP_W  = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;

  logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] vld_q;

  logic [LIMIT_W-1:0]   slot_limit_q;
  logic [WPTR_W-1:0]    ptr_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [WORD_BITS-1:0] free_q;
  logic [REQ_W-1:0]     found_q;
  logic [REQ_W-1:0]     req_q;
  logic                 out_valid_q;
  logic [INDEX_W-1:0]   slot_index_q;
  status_e              status_q;
  logic                 last_q;

  logic [8:0]           wsel_ext;
  logic                 wsel_ok;
  logic [WPTR_W-1:0]    wr_addr;
  logic [REQ_W-1:0]     req_sat;
  logic [WORD_BITS-1:0] pick_oh;
  logic [BIT_W-1:0]     pick_bit;
  logic [CMP_W-1:0]     cur_idx;

  assign wsel_ext = 9'(word_select_i);
  assign wsel_ok  = wsel_ext < 9'(BITMAP_WORDS);
  assign wr_addr  = wsel_ext[WPTR_W-1:0];

  always_comb begin
    priority if (requested_i == '0) begin
      req_sat = REQ_W'(1);
    end else if (requested_i > REQ_W'(MAX_REQUEST)) begin
      req_sat = REQ_W'(MAX_REQUEST);
    end else begin
      req_sat = requested_i;
    end
  end

  // Lowest free bit of the current word.
  assign pick_oh  = free_q & (~free_q + WORD_BITS'(1));
  assign pick_bit = onehot_to_bin(pick_oh);
  assign cur_idx  = CMP_W'({ptr_q, pick_bit});

  assign sts_o.word_empty = (free_q == '0);
  assign sts_o.word_last  = (ptr_q == WPTR_W'(BITMAP_WORDS - 1));
  assign sts_o.over_lim   = (cur_idx >= CMP_W'(slot_limit_q));
  assign sts_o.count_hit  = ((found_q + REQ_W'(1)) == req_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wsel_ok) begin
      mem[wr_addr] <= word_value_i;
    end
    if (cmd_i.rd_word) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      slot_limit_q <= LIMIT_RESET;
      ptr_q        <= '0;
      rd_vld_q     <= 1'b0;
      free_q       <= '0;
      found_q      <= '0;
      req_q        <= REQ_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        slot_limit_q <= cfg_wr_data_i;
      end
      if (cmd_i.wr_en && wsel_ok) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.start) begin
        ptr_q   <= '0;
        found_q <= '0;
        req_q   <= req_sat;
      end else if (cmd_i.next_word) begin
        ptr_q <= ptr_q + WPTR_W'(1);
      end
      if (cmd_i.rd_word) begin
        rd_vld_q <= vld_q[ptr_q];
      end
      if (cmd_i.load_word) begin
        free_q <= rd_vld_q ? ~rd_data_q : '1;
      end else if (cmd_i.emit) begin
        free_q  <= free_q & ~pick_oh;
        found_q <= found_q + REQ_W'(1);
      end
      out_valid_q <= cmd_i.emit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      slot_index_q <= (cmd_i.emit_status == ST_NONE) ? '0 : cur_idx[INDEX_W-1:0];
      status_q     <= cmd_i.emit_status;
      last_q       <= cmd_i.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_index_o = slot_index_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

`ifndef SYNTH
  // An over-limit beat carries an index that really is at or above the limit.
  a_over_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_status == ST_OVER) |-> (sts_o.over_lim && !sts_o.word_empty))
    else $error("over-limit beat without a free index over the limit");

  // A non-final ok beat leaves the count below the request.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_status == ST_OK && !cmd_i.emit_last) |=> (found_q < req_q))
    else $error("found count passed the request");
`endif

endmodule

// ===== rtl/bitmap_free_slot_finder.sv =====
// ----------------------------------------------------------------------------
// bitmap_free_slot_finder
// Occupancy bitmap with a scan that reports free slot indices in rising order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Beat contents
//   --------  ---------  -------------------------  ---------------------------
//   in        sink       in_valid_i / in_stall_o    action, word, value, count
//   out       source     out_valid_o / out_stall_i  slot_index, status, last
//   cfg       sink       cfg_wr_en_i                slot_limit (11 bits)
//
// A write beat returns no result. A request beat is accepted, then each bitmap
// word goes through memory read, mask load and check, a sequence set by the
// single-port memory; the check yields one priority pick per cycle while the
// output register can take the result beat.
// Reset frees every word through per-word valid bits. A stalled result beat
// holds the scan; a new input beat is taken once the final beat is registered.
//
module bitmap_free_slot_finder
  import bfsf_pkg::*;
#(
  parameter int BITMAP_WORDS = 32,
  parameter int MAX_REQUEST  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: slot limit register.
  input  logic                 cfg_wr_en_i,
  input  logic [LIMIT_W-1:0]   cfg_wr_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [WSEL_W-1:0]    word_select_i,
  input  logic [WORD_BITS-1:0] word_value_i,
  input  logic [REQ_W-1:0]     requested_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [INDEX_W-1:0]   slot_index_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  // Commands from the sequencer to the datapath, status back.
  cmd_t cmd;
  sts_t sts;

  // The sequencer owns input acceptance and the decision of which result
  // beat to produce; it never touches payload.
  bfsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the bitmap, the scan pointer, the free mask of the
  // word under inspection and the output register that decouples the scan
  // from a stalled receiver.
  bfsf_dp #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .MAX_REQUEST  (MAX_REQUEST)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .word_select_i (word_select_i),
    .word_value_i  (word_value_i),
    .requested_i   (requested_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .slot_index_o  (slot_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap free-slot finder: bitmap word loads and
// slot requests go in, and every result beat is checked against a spelled-out
// result or an in-bench scan of a private copy of the bitmap and the slot limit.
// ----------------------------------------------------------------------------
module tb_top;
  import bfsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WORDS = 32;
  localparam int NUM_SLOTS = NUM_WORDS * WORD_BITS;
  localparam int MAX_COUNT = 64;

  // Bound on the worst request, from the per-word steps and the result beats.
  // The settle pause is sized from it; the watchdog is not.
  localparam int SCAN_CYCLES = 3 * NUM_WORDS + MAX_COUNT + 1;
  localparam int SETTLE      = SCAN_CYCLES + 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_PHASES = 5;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    status_e            status;
    logic               last;
  } slot_result_t;

  localparam slot_result_t NO_TYPED = '0;

  // The directed part is a list of rows: a single beat, a fill of every
  // bitmap word with one value, or a new slot limit.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_FILL,
    ROW_LIMIT
  } plan_kind_e;

  typedef struct {
    plan_kind_e          kind;
    logic                action;
    logic [WSEL_W-1:0]   wsel;
    logic [WORD_BITS-1:0] wval;   // also the fill value or the new limit
    logic [REQ_W-1:0]    count;
    bit                  typed;   // use the spelled-out result below
    slot_result_t        want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_wr_en_i = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 action_i = ACT_WRITE;
  logic [WSEL_W-1:0]    word_select_i = '0;
  logic [WORD_BITS-1:0] word_value_i = '0;
  logic [REQ_W-1:0]     requested_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [INDEX_W-1:0]   slot_index_o;
  logic [1:0]           status_o;
  logic                 last_o;

  // Private copy of the block's state, updated at each accepted input beat and limit write.
  logic [WORD_BITS-1:0] occ_words [NUM_WORDS];
  logic [LIMIT_W-1:0]   limit_reg = LIMIT_RESET;
  slot_result_t         pending_slots [$];
  plan_row_t            plan [$];

  bit          no_idle = 1'b0;   // when set, neither side inserts gaps
  int unsigned hold = 0;         // remaining stall cycles on the result side
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned limits_written = 0;
  int unsigned seen_ok = 0;
  int unsigned seen_over = 0;
  int unsigned seen_none = 0;

  bitmap_free_slot_finder #(
    .BITMAP_WORDS(NUM_WORDS),
    .MAX_REQUEST (MAX_COUNT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .word_select_i(word_select_i),
    .word_value_i (word_value_i),
    .requested_i  (requested_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_index_o (slot_index_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Mostly legal counts, now and then anything the 7-bit field can carry so
  // that zero and counts above the maximum keep turning up.
  function automatic logic [REQ_W-1:0] pick_count();
    if ($urandom_range(0, 7) == 0) begin
      return REQ_W'($urandom_range(0, 127));
    end
    return REQ_W'($urandom_range(1, MAX_COUNT));
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void expect_slot(input int idx, input status_e st, input logic last);
    slot_result_t r;
    r.slot_index = INDEX_W'(idx);
    r.status     = st;
    r.last       = last;
    pending_slots.push_back(r);
  endfunction

  // Walks the bitmap from slot 0 upward and queues the beats a request
  // should produce. A zero count behaves as one and counts are capped at the
  // maximum. The first free slot at or past the limit ends the run, and a
  // scan that runs off the end of the bitmap ends in a none-free beat.
  function automatic void scan_for_free(input logic [REQ_W-1:0] count);
    int unsigned wanted;
    int unsigned found;
    wanted = (count == 0) ? 1 : ((count > MAX_COUNT) ? MAX_COUNT : count);
    found  = 0;
    for (int idx = 0; idx < NUM_SLOTS; idx++) begin
      if (occ_words[idx / WORD_BITS][idx % WORD_BITS] == 1'b0) begin
        if (idx >= limit_reg) begin
          expect_slot(idx, ST_OVER, 1'b1);
          return;
        end
        found++;
        expect_slot(idx, ST_OK, found == wanted);
        if (found == wanted) begin
          return;
        end
      end
    end
    expect_slot(0, ST_NONE, 1'b1);
  endfunction

  function automatic void add_row(input plan_kind_e kind, input logic act,
                                  input logic [WSEL_W-1:0] ws,
                                  input logic [WORD_BITS-1:0] wv,
                                  input logic [REQ_W-1:0] count, input bit typed,
                                  input int idx, input status_e st, input logic last);
    plan_row_t r;
    r.kind            = kind;
    r.action          = act;
    r.wsel            = ws;
    r.wval            = wv;
    r.count           = count;
    r.typed           = typed;
    r.want.slot_index = INDEX_W'(idx);
    r.want.status     = st;
    r.want.last       = last;
    plan.push_back(r);
  endfunction

  // Presents one input beat and holds it until the block takes it. Valid is
  // left high on return; the caller decides whether a gap follows. The
  // private state is updated at the accepting edge, before any of this beat's
  // results can appear.
  task automatic send_beat(input logic act, input logic [WSEL_W-1:0] ws,
                           input logic [WORD_BITS-1:0] wv,
                           input logic [REQ_W-1:0] count,
                           input bit typed, input slot_result_t want);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    word_select_i <= ws;
    word_value_i  <= wv;
    requested_i   <= count;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i === 1'b1 && in_stall_o === 1'b0));
    beats_sent++;
    if (act == ACT_WRITE) begin
      occ_words[ws] = wv;
    end else begin
      requests_sent++;
      if (typed) begin
        pending_slots.push_back(want);
      end else begin
        scan_for_free(count);
      end
    end
  endtask

  task automatic rest_sender();
    int unsigned n;
    n = pick_wait();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_slots.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // The limit only changes with the block idle: every result in, then a
  // pause long enough for a scan that might still be winding down.
  task automatic program_limit(input logic [LIMIT_W-1:0] lim);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= lim;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    limit_reg = lim;
    limits_written++;
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then draw a stall for the next one. While idle it sometimes raises stall
  // on its own so that the first beat of a run gets held up too.
  always @(posedge clk_i) begin : result_check
    slot_result_t want;
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        if (status_o == ST_OK) begin
          seen_ok++;
        end else if (status_o == ST_OVER) begin
          seen_over++;
        end else begin
          seen_none++;
        end
        if (pending_slots.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected: slot_index %0d status %0d last %0d",
                   $time, slot_index_o, status_o, last_o);
        end else begin
          want = pending_slots.pop_front();
          if (slot_index_o !== want.slot_index) begin
            mismatches++;
            $display("%0t: slot_index expected %0d, got %0d",
                     $time, want.slot_index, slot_index_o);
          end
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          end
          if (last_o !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0d, got %0d", $time, want.last, last_o);
          end
        end
        hold = pick_wait();
        if (hold != 0) begin
          out_stall_i <= 1'b1;
        end
      end else if (hold != 0) begin
        hold--;
        if (hold == 0) begin
          out_stall_i <= 1'b0;
        end
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run of cycles in which no beat moves on either channel means
  // the block has hung or lost a result.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i == 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_slots.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t            r;
    logic [LIMIT_W-1:0]   lim;
    logic [WORD_BITS-1:0] v;
    int unsigned          quota;
    int unsigned          phase_start;
    int unsigned          n;

    foreach (occ_words[i]) begin
      occ_words[i] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Fields that a beat's action ignores carry junk on
    // purpose. Rows with a result spelled out are single-beat runs whose
    // answer is obvious from the bitmap; the rest go through the scan.
    // Right after reset every slot is free and the limit is 1024.
    add_row(ROW_ITEM, ACT_REQUEST, 5'h1F, 32'hFFFF_FFFF, 7'd1,  1, 0, ST_OK, 1'b1);
    // A zero count behaves as a count of one.
    add_row(ROW_ITEM, ACT_REQUEST, 5'h00, 32'h0000_0000, 7'd0,  1, 0, ST_OK, 1'b1);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h15, 32'hA5A5_5A5A, 7'd64, 0, 0, ST_OK, 1'b0);
    // Counts past the maximum saturate.
    add_row(ROW_ITEM, ACT_REQUEST, 5'h0A, 32'h5A5A_A5A5, 7'h7F, 0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_WRITE,   5'd0,  32'hFFFF_FFFF, 7'h7F, 0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h1F, 32'h0000_0000, 7'd1,  1, 32, ST_OK, 1'b1);
    add_row(ROW_ITEM, ACT_WRITE,   5'd1,  32'hFFFF_FFFE, 7'd0,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_WRITE,   5'd2,  32'h5555_5555, 7'd64, 0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_WRITE,   5'd3,  32'hAAAA_AAAA, 7'h55, 0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h11, 32'h1234_5678, 7'd40, 0, 0, ST_OK, 1'b0);
    // A zero limit turns the very first free slot into an over-limit beat.
    add_row(ROW_LIMIT, ACT_WRITE,  5'd0,  32'd0,         7'd0,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h0F, 32'hFFFF_0000, 7'd5,  1, 32, ST_OVER, 1'b1);
    // A limit that cuts a run off partway through.
    add_row(ROW_LIMIT, ACT_WRITE,  5'd0,  32'd70,        7'd0,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h07, 32'h0000_FFFF, 7'd20, 0, 0, ST_OK, 1'b0);
    add_row(ROW_LIMIT, ACT_WRITE,  5'd0,  32'd2047,      7'd0,  0, 0, ST_OK, 1'b0);
    // Whole bitmap used: the scan runs off the end.
    add_row(ROW_FILL, ACT_WRITE,   5'd0,  32'hFFFF_FFFF, 7'd0,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h1E, 32'h8000_0001, 7'd1,  1, 0, ST_NONE, 1'b1);
    // Only the topmost slot free.
    add_row(ROW_ITEM, ACT_WRITE,   5'd31, 32'h7FFF_FFFF, 7'd1,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h01, 32'hFFFF_FFFF, 7'd1,  1, 1023, ST_OK, 1'b1);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h02, 32'h0F0F_0F0F, 7'd2,  0, 0, ST_OK, 1'b0);
    add_row(ROW_LIMIT, ACT_WRITE,  5'd0,  32'd1023,      7'd0,  0, 0, ST_OK, 1'b0);
    add_row(ROW_ITEM, ACT_REQUEST, 5'h1F, 32'hF0F0_F0F0, 7'd64, 1, 1023, ST_OVER, 1'b1);

    foreach (plan[i]) begin
      r = plan[i];
      case (r.kind)
        ROW_ITEM: begin
          send_beat(r.action, r.wsel, r.wval, r.count, r.typed, r.want);
          rest_sender();
        end
        ROW_FILL: begin
          for (int w = 0; w < NUM_WORDS; w++) begin
            send_beat(ACT_WRITE, WSEL_W'(w), r.wval, pick_count(), 1'b0, NO_TYPED);
            rest_sender();
          end
        end
        default: begin
          program_limit(r.wval[LIMIT_W-1:0]);
        end
      endcase
    end

    // Random part, in phases with different limits. The tiny limits make
    // nearly every request end at once, so those phases stay short.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: lim = '1;
        1: lim = '0;
        2: lim = LIMIT_W'($urandom_range(1, NUM_SLOTS - 1));
        3: lim = LIMIT_RESET;
        default: lim = LIMIT_W'(1);
      endcase
      program_limit(lim);
      quota       = (lim < 2) ? 8 : 18;
      phase_start = beats_sent;
      while (beats_sent - phase_start < quota) begin
        // Some episodes run with no gaps on either side at all.
        no_idle = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
          0: begin
            // A few scattered word loads, then one request.
            n = $urandom_range(1, 3);
            repeat (n) begin
              send_beat(ACT_WRITE, WSEL_W'($urandom), pick_word(), pick_count(),
                        1'b0, NO_TYPED);
              rest_sender();
            end
            send_beat(ACT_REQUEST, WSEL_W'($urandom), $urandom, pick_count(),
                      1'b0, NO_TYPED);
            rest_sender();
          end
          1: begin
            // Pack the low words nearly full so the scan has to go deep.
            n = $urandom_range(2, 8);
            for (int w = 0; w < n; w++) begin
              case ($urandom_range(0, 2))
                0: v = '1;
                1: v = ~(32'h1 << $urandom_range(0, 31));
                default: v = $urandom | $urandom;
              endcase
              send_beat(ACT_WRITE, WSEL_W'(w), v, pick_count(), 1'b0, NO_TYPED);
              rest_sender();
            end
            send_beat(ACT_REQUEST, WSEL_W'($urandom), $urandom, pick_count(),
                      1'b0, NO_TYPED);
            rest_sender();
          end
          2: begin
            // Requests back to back against the same bitmap.
            n = $urandom_range(2, 4);
            repeat (n) begin
              send_beat(ACT_REQUEST, WSEL_W'($urandom), $urandom, pick_count(),
                        1'b0, NO_TYPED);
              rest_sender();
            end
          end
          default: begin
            // Noise: any action with any field values.
            send_beat(1'($urandom_range(0, 1)), WSEL_W'($urandom), pick_word(),
                      REQ_W'($urandom_range(0, 127)), 1'b0, NO_TYPED);
            rest_sender();
          end
        endcase
        // Now and then let the block drain completely before going on.
        if ($urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
      end
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("Ran %0d input beats, %0d of them slot requests, under %0d slot limit settings.",
             beats_sent, requests_sent, limits_written);
    $display("Checked %0d ok beats, %0d over-limit beats and %0d none-free beats.",
             seen_ok, seen_over, seen_none);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
